[hw/rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: command codes, sequencer states,
// output field widths and the divider status struct.
// No dependencies.
package rau_pkg;

    // Output field widths
    localparam int NUM_BITS = 33;
    localparam int DEN_BITS = 32;

    // Operation codes on the command field
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMBINE,
        ST_EUC_GO,
        ST_EUC_WAIT,
        ST_QN_GO,
        ST_QN_WAIT,
        ST_QD_GO,
        ST_QD_WAIT,
        ST_DONE
    } state_t;

    // Status from the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hw/rtl/rau_if.sv]
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on nothing; operand width is an interface parameter.
interface rau_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;

    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] res_num;
    logic signed [31:0] res_den;
    logic               zero_den_error;

    modport source (output valid, res_num, res_den, zero_den_error, input ready);
    modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

[hw/rtl/rau_divider.sv]
// Shared signed divider: restoring, one quotient bit per cycle, truncating.
// Depends on rau_pkg (div_status_t).
module rau_divider #(
    parameter int WIDTH = 33
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [WIDTH-1:0] dividend,
    input  logic signed [WIDTH-1:0] divisor,
    output logic signed [WIDTH-1:0] quotient,
    output logic signed [WIDTH-1:0] remainder,
    output rau_pkg::div_status_t    status
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // One restoring step per cycle; magnitudes at start
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        shifted    = {rem_reg, quo_reg[WIDTH-1]};
        diff       = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            quo_next   = dividend[WIDTH-1] ? WIDTH'(-dividend) : WIDTH'(dividend);
            dsr_next   = divisor[WIDTH-1] ? WIDTH'(-divisor) : WIDTH'(divisor);
            rem_next   = '0;
            neg_q_next = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            neg_r_next = dividend[WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // Apply signs: quotient by xor, remainder follows dividend
    assign quotient    = neg_q_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign remainder   = neg_r_reg ? -$signed(rem_reg) : $signed(rem_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[hw/rtl/rational_arith_unit_top.sv]
// Rational arithmetic unit top level: shared multiplier, sequencer, Euclid
// reduction on the shared divider. Depends on rau_pkg, rau_if, rau_divider.
//
// Channel    Dir  Fields
// operands   in   command[1:0]; a_num, a_den, b_num, b_den (OPERAND_WIDTH each)
// result     out  res_num[32:0], res_den[31:0], zero_den_error
//
// One transaction at a time: after accept the sequencer runs the three multiplies,
// COMBINE, the Euclid steps and the two reducing divides on the one-bit-per-cycle
// divider (N = 2*OPERAND_WIDTH+1 bits, 33 by default). A zero input denominator
// goes straight to DONE, a zero result denominator from COMBINE.
// Reset clears the sequencer and the result valid; nothing else to clear.
// A result held by a stalled sink does not block the next accept; the
// following result waits in DONE until the output register frees up.
module rational_arith_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    rau_in_if.sink         operands,
    rau_out_if.source      result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 1;

    rau_pkg::state_t state_reg, state_next;
    rau_pkg::cmd_t   cmd_reg, cmd_next;

    logic signed [W-1:0]  an_reg, an_next, ad_reg, ad_next;
    logic signed [W-1:0]  bn_reg, bn_next, bd_reg, bd_next;
    logic signed [PW-1:0] t1_reg, t1_next, t2_reg, t2_next;
    logic signed [NW-1:0] num_reg, num_next, den_reg, den_next;
    logic signed [NW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [NW-1:0] qn_reg, qn_next, qd_reg, qd_next;
    logic                 err_reg, err_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [32:0]   res_num_reg, res_num_next;
    logic signed [31:0]   res_den_reg, res_den_next;
    logic                 res_err_reg, res_err_next;

    logic signed [W-1:0]  mul_x, mul_y;
    logic signed [PW-1:0] product;

    logic                 div_start;
    logic signed [NW-1:0] div_dividend, div_divisor;
    logic signed [NW-1:0] div_quotient, div_remainder;
    rau_pkg::div_status_t div_status;

    logic signed [63:0]   qn_ext, qd_ext;

    // Shared divider
    rau_divider #(
        .WIDTH (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    // Shared multiplier
    assign product = mul_x * mul_y;

    // Quotients widened before taking the output field bits
    assign qn_ext = 64'(qn_reg);
    assign qd_ext = 64'(qd_reg);

    assign operands.ready        = (state_reg == rau_pkg::ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.res_num        = res_num_reg;
    assign result.res_den        = res_den_reg;
    assign result.zero_den_error = res_err_reg;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        qn_next        = qn_reg;
        qd_next        = qd_reg;
        err_next       = err_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !result.ready;
        mul_x          = ad_reg;
        mul_y          = bd_reg;
        div_start      = 1'b0;
        div_dividend   = x_reg;
        div_divisor    = y_reg;

        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                if (operands.valid)
                begin
                    cmd_next = rau_pkg::cmd_t'(operands.command);
                    an_next  = operands.a_num;
                    ad_next  = operands.a_den;
                    bn_next  = operands.b_num;
                    bd_next  = operands.b_den;
                    err_next = (operands.a_den == '0) || (operands.b_den == '0);
                    state_next = ((operands.a_den == '0) || (operands.b_den == '0)) ?
                                 rau_pkg::ST_DONE : rau_pkg::ST_MUL0;
                end
            end

            // First numerator term
            rau_pkg::ST_MUL0:
            begin
                mul_x      = an_reg;
                mul_y      = (cmd_reg == rau_pkg::CMD_MUL) ? bn_reg : bd_reg;
                t1_next    = product;
                state_next = rau_pkg::ST_MUL1;
            end

            // Second numerator term (add and subtract)
            rau_pkg::ST_MUL1:
            begin
                mul_x      = ad_reg;
                mul_y      = bn_reg;
                t2_next    = product;
                state_next = rau_pkg::ST_MUL2;
            end

            // Denominator
            rau_pkg::ST_MUL2:
            begin
                mul_x      = ad_reg;
                mul_y      = (cmd_reg == rau_pkg::CMD_DIV) ? bn_reg : bd_reg;
                den_next   = NW'(product);
                state_next = rau_pkg::ST_COMBINE;
            end

            // Form the numerator, catch a zero result denominator
            rau_pkg::ST_COMBINE:
            begin
                case (cmd_reg)
                    rau_pkg::CMD_ADD: num_next = NW'(t1_reg) + NW'(t2_reg);
                    rau_pkg::CMD_SUB: num_next = NW'(t1_reg) - NW'(t2_reg);
                    default:          num_next = NW'(t1_reg);
                endcase
                x_next = num_next;
                y_next = den_reg;
                if (den_reg == '0)
                begin
                    err_next   = 1'b1;
                    state_next = rau_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rau_pkg::ST_EUC_GO;
                end
            end

            // Euclid step: x rem y
            rau_pkg::ST_EUC_GO:
            begin
                div_start  = 1'b1;
                state_next = rau_pkg::ST_EUC_WAIT;
            end

            rau_pkg::ST_EUC_WAIT:
            begin
                if (div_status.done)
                begin
                    if (div_remainder == '0)
                    begin
                        state_next = rau_pkg::ST_QN_GO;
                    end
                    else
                    begin
                        x_next     = y_reg;
                        y_next     = div_remainder;
                        state_next = rau_pkg::ST_EUC_GO;
                    end
                end
            end

            // Reduce numerator by the final divisor
            rau_pkg::ST_QN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                state_next   = rau_pkg::ST_QN_WAIT;
            end

            rau_pkg::ST_QN_WAIT:
            begin
                if (div_status.done)
                begin
                    qn_next    = div_quotient;
                    state_next = rau_pkg::ST_QD_GO;
                end
            end

            // Reduce denominator by the final divisor
            rau_pkg::ST_QD_GO:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                state_next   = rau_pkg::ST_QD_WAIT;
            end

            rau_pkg::ST_QD_WAIT:
            begin
                if (div_status.done)
                begin
                    qd_next    = div_quotient;
                    state_next = rau_pkg::ST_DONE;
                end
            end

            // Load the output register once it is free
            rau_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    res_err_next   = err_reg;
                    res_num_next   = err_reg ? '0 : qn_ext[rau_pkg::NUM_BITS-1:0];
                    res_den_next   = err_reg ? '0 : qd_ext[rau_pkg::DEN_BITS-1:0];
                    state_next     = rau_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rau_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        qn_reg      <= qn_next;
        qd_reg      <= qd_next;
        err_reg     <= err_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_err_reg <= res_err_next;
    end

endmodule

[tb/tb_rational_arith_unit_top.sv]
// Testbench for rational_arith_unit_top: directed and random fraction transactions,
// with random idle bursts on both channels and a scoreboard that predicts each result.
// Depends on rau_pkg, rau_if and the rational_arith_unit_top RTL.
`timescale 1ns / 1ps

module tb_rational_arith_unit_top;

    localparam int OPERAND_WIDTH = 16;
    localparam int N_RANDOM      = 1080;
    localparam int QUIET_TAIL    = 100;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 2000;

    // One operand transaction and one result transaction
    typedef struct {
        rau_pkg::cmd_t                   command;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } operands_t;

    typedef struct {
        logic signed [rau_pkg::NUM_BITS-1:0] num;
        logic signed [rau_pkg::DEN_BITS-1:0] den;
        logic                                zero_den;
    } fraction_t;

    // Scoreboard: predicts reduced fractions and checks them in order
    class fraction_scoreboard;
        fraction_t expected_fracs[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Cross-multiply, then divide by the last nonzero Euclid divisor
        function fraction_t reduced_fraction(operands_t t);
            longint    an, ad, bn, bd, num, den, x, y, r, qn, qd;
            fraction_t o;
            o.num      = '0;
            o.den      = '0;
            o.zero_den = 1'b0;
            an = longint'(t.a_num);
            ad = longint'(t.a_den);
            bn = longint'(t.b_num);
            bd = longint'(t.b_den);
            if (ad == 0 || bd == 0)
            begin
                o.zero_den = 1'b1;
                return o;
            end
            case (t.command)
                rau_pkg::CMD_ADD:
                begin
                    num = an * bd + ad * bn;
                    den = ad * bd;
                end
                rau_pkg::CMD_SUB:
                begin
                    num = an * bd - ad * bn;
                    den = ad * bd;
                end
                rau_pkg::CMD_MUL:
                begin
                    num = an * bn;
                    den = ad * bd;
                end
                default:
                begin
                    num = an * bd;
                    den = ad * bn;
                end
            endcase
            // divide by zero on the result denominator
            if (den == 0)
            begin
                o.zero_den = 1'b1;
                return o;
            end
            x = num;
            y = den;
            r = x % y;
            while (r != 0)
            begin
                x = y;
                y = r;
                r = x % y;
            end
            qn    = num / y;
            qd    = den / y;
            o.num = qn[rau_pkg::NUM_BITS-1:0];
            o.den = qd[rau_pkg::DEN_BITS-1:0];
            return o;
        endfunction

        function void note_operands(operands_t t);
            expected_fracs.push_back(reduced_fraction(t));
        endfunction

        function void check_result(fraction_t got);
            fraction_t exp_f;
            if (expected_fracs.size() == 0)
            begin
                $display("%0t: unexpected result num %0d den %0d err %0b",
                         $time, got.num, got.den, got.zero_den);
                errors++;
                return;
            end
            exp_f = expected_fracs.pop_front();
            if (got.num !== exp_f.num)
            begin
                $display("%0t: res_num expected %0d, got %0d", $time, exp_f.num, got.num);
                errors++;
            end
            if (got.den !== exp_f.den)
            begin
                $display("%0t: res_den expected %0d, got %0d", $time, exp_f.den, got.den);
                errors++;
            end
            if (got.zero_den !== exp_f.zero_den)
            begin
                $display("%0t: zero_den_error expected %0b, got %0b",
                         $time, exp_f.zero_den, got.zero_den);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;         // set for calm stretches and for the tail of the run
    int   idle_cycles = 0; // watchdog count of cycles with no accepted transaction

    rau_in_if #(.W(OPERAND_WIDTH)) operands_if();
    rau_out_if                     result_if();

    fraction_scoreboard frac_sb = new();

    rational_arith_unit_top #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .result   (result_if)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        fraction_t got;
        if (result_if.valid && result_if.ready)
        begin
            got.num      = result_if.res_num;
            got.den      = result_if.res_den;
            got.zero_den = result_if.zero_den_error;
            frac_sb.check_result(got);
        end
        if ((result_if.valid && result_if.ready) || (operands_if.valid && operands_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[rational_arith_unit_top] ERROR");
            $finish;
        end
    end

    // Result sink: ready with random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_if.ready = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 17) - 1;
                result_if.ready = 1'b0;
            end
            else
                result_if.ready = 1'b1;
        end
    end

    function automatic operands_t make_ops(rau_pkg::cmd_t c, int an, int ad, int bn, int bd);
        operands_t t;
        t.command = c;
        t.a_num   = OPERAND_WIDTH'(an);
        t.a_den   = OPERAND_WIDTH'(ad);
        t.b_num   = OPERAND_WIDTH'(bn);
        t.b_den   = OPERAND_WIDTH'(bd);
        return t;
    endfunction

    // Random field: full range, small values, extremes, smooth numbers, powers of two
    function automatic logic [OPERAND_WIDTH-1:0] rand_field();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = int'($urandom_range(0, 60)) - 30;
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            end
            8:
            begin
                v = $urandom_range(1, 12) * $urandom_range(1, 12) * $urandom_range(1, 12);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                v = 1 << $urandom_range(0, 15);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v[OPERAND_WIDTH-1:0];
    endfunction

    // Drive one operand transaction, with an optional idle burst before it
    task automatic send_operands(operands_t t);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            operands_if.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        operands_if.valid   = 1'b1;
        operands_if.command = t.command;
        operands_if.a_num   = t.a_num;
        operands_if.a_den   = t.a_den;
        operands_if.b_num   = t.b_num;
        operands_if.b_den   = t.b_den;
        do
            @(posedge clk);
        while (!operands_if.ready);
        frac_sb.note_operands(t);
        @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        operands_t directed[$];
        operands_t t;
        rst_n               = 1'b0;
        no_idle             = 1'b0;
        operands_if.valid   = 1'b0;
        operands_if.command = rau_pkg::CMD_ADD;
        operands_if.a_num   = '0;
        operands_if.a_den   = '0;
        operands_if.b_num   = '0;
        operands_if.b_den   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every command, field extremes, zero and negative denominators
        directed.push_back(make_ops(rau_pkg::CMD_ADD, 1, 2, 1, 3));
        directed.push_back(make_ops(rau_pkg::CMD_SUB, 1, 2, 1, 2));
        directed.push_back(make_ops(rau_pkg::CMD_MUL, -3, 4, 2, -5));
        directed.push_back(make_ops(rau_pkg::CMD_DIV, 3, 4, 5, 6));
        directed.push_back(make_ops(rau_pkg::CMD_ADD, 0, 5, 0, 7));
        directed.push_back(make_ops(rau_pkg::CMD_MUL, 0, -9, 4, 3));
        directed.push_back(make_ops(rau_pkg::CMD_ADD, 3, 0, 1, 2));
        directed.push_back(make_ops(rau_pkg::CMD_SUB, 3, 4, 1, 0));
        directed.push_back(make_ops(rau_pkg::CMD_DIV, 3, 4, 0, 5));
        directed.push_back(make_ops(rau_pkg::CMD_DIV, 3, 0, 0, 0));
        directed.push_back(make_ops(rau_pkg::CMD_MUL, 32767, 32767, 32767, 32767));
        directed.push_back(make_ops(rau_pkg::CMD_MUL, -32768, -32768, -32768, -32768));
        directed.push_back(make_ops(rau_pkg::CMD_ADD, 32767, -32768, -32768, 32767));
        directed.push_back(make_ops(rau_pkg::CMD_SUB, -32768, 32767, 32767, -32768));
        directed.push_back(make_ops(rau_pkg::CMD_ADD, -32768, 1, -32768, 1));
        directed.push_back(make_ops(rau_pkg::CMD_ADD, -32768, -32768, -32768, -32768));
        directed.push_back(make_ops(rau_pkg::CMD_DIV, 1, 1, 1, 1));
        directed.push_back(make_ops(rau_pkg::CMD_DIV, -1, 1, 1, -1));
        directed.push_back(make_ops(rau_pkg::CMD_DIV, -32768, 32767, 32767, -32768));
        directed.push_back(make_ops(rau_pkg::CMD_MUL, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
        directed.push_back(make_ops(rau_pkg::CMD_SUB, 7, -3, -2, 9));
        directed.push_back(make_ops(rau_pkg::CMD_ADD, -1, -1, -1, -1));
        directed.push_back(make_ops(rau_pkg::CMD_SUB, 32767, 1, -32768, 1));
        foreach (directed[i])
            send_operands(directed[i]);

        // Random: calm stretches alternate with bursty ones, tail is calm
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i >= N_RANDOM - QUIET_TAIL)
                no_idle = 1'b1;
            else
                no_idle = ((i / 100) % 3 == 2);
            t.command = rau_pkg::cmd_t'($urandom_range(0, 3));
            t.a_num   = rand_field();
            t.a_den   = rand_field();
            t.b_num   = rand_field();
            t.b_den   = rand_field();
            send_operands(t);
        end
        operands_if.valid = 1'b0;

        // Drain, then wait DRAIN_CYCLES more to catch stray results
        while (frac_sb.expected_fracs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (frac_sb.errors == 0)
            $display("[rational_arith_unit_top] OK");
        else
            $display("[rational_arith_unit_top] ERROR");
        $finish;
    end

endmodule
